/* design/gfp_pkg.sv */
package gfp_pkg;

    // Payload buffer size in bytes.
    localparam int MAX_PAYLOAD = 64;

    // Byte address, length counter and word address widths of the payload buffer.
    localparam int BA_W    = $clog2(MAX_PAYLOAD);
    localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int WORDS   = (MAX_PAYLOAD + 3) / 4;
    localparam int WADDR_W = $clog2(WORDS);

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0] CLASS_NAV  = 8'h01;
    localparam logic [7:0] ID_POSLLH  = 8'h02;
    localparam logic [7:0] ID_SOL     = 8'h06;

    localparam logic [7:0] FIX_CODE_2D = 8'h02;
    localparam logic [7:0] FIX_CODE_3D = 8'h03;

    localparam logic [1:0] FIX_NONE = 2'd0;
    localparam logic [1:0] FIX_2D   = 2'd1;
    localparam logic [1:0] FIX_3D   = 2'd2;

    // Payload offsets of the decoded fields.
    localparam int OFS_LON  = 4;
    localparam int OFS_LAT  = 8;
    localparam int OFS_FIX  = 10;
    localparam int OFS_SATS = 47;

    localparam logic [WADDR_W-1:0] WORD_LON  = WADDR_W'(OFS_LON / 4);
    localparam logic [WADDR_W-1:0] WORD_LAT  = WADDR_W'(OFS_LAT / 4);
    localparam logic [WADDR_W-1:0] WORD_SATS = WADDR_W'(OFS_SATS / 4);
    localparam logic [1:0]         LANE_FIX  = 2'(OFS_FIX % 4);
    localparam logic [1:0]         LANE_SATS = 2'(OFS_SATS % 4);

    localparam int OUT_DATA_W = 96;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_CKA,
        PH_CKB
    } phase_t;

    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
        logic [1:0]         lane;
        logic [7:0]         data;
    } ram_wr_t;

    typedef struct packed {
        logic [WADDR_W-1:0] a_addr;
        logic [WADDR_W-1:0] b_addr;
    } ram_rd_addr_t;

    typedef struct packed {
        logic [31:0] a_data;
        logic [31:0] b_data;
    } ram_rd_data_t;

    typedef struct packed {
        logic               frame_ok;
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
        logic [7:0]         satellites;
        logic [1:0]         fix_state;
        logic [15:0]        frame_count;
    } result_t;

    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] lane);
        return w[lane*8 +: 8];
    endfunction

endpackage

/* design/gfp_payload_ram.sv */
module gfp_payload_ram
    import gfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ram_wr_t      wr,
    input  ram_rd_addr_t rd_addr,
    output ram_rd_data_t rd_data
);

    logic [31:0] mem [WORDS];
    logic [WORDS-1:0] valid_reg;
    logic [31:0] a_data_reg;
    logic [31:0] b_data_reg;
    logic        a_valid_reg;
    logic        b_valid_reg;

    // A word never written since reset reads as zero. The first byte written into
    // such a word also clears its other lanes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            for (int i = 0; i < 4; i++) begin
                if (2'(i) == wr.lane) begin
                    mem[wr.addr][i*8 +: 8] <= wr.data;
                end else if (!valid_reg[wr.addr]) begin
                    mem[wr.addr][i*8 +: 8] <= 8'h00;
                end
            end
        end
        a_data_reg  <= mem[rd_addr.a_addr];
        b_data_reg  <= mem[rd_addr.b_addr];
        a_valid_reg <= valid_reg[rd_addr.a_addr];
        b_valid_reg <= valid_reg[rd_addr.b_addr];
    end

    assign rd_data.a_data = a_valid_reg ? a_data_reg : 32'h0;
    assign rd_data.b_data = b_valid_reg ? b_data_reg : 32'h0;

endmodule

/* design/gfp_parser.sv */
module gfp_parser
    import gfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_fire,
    input  logic [7:0]   rx_byte,
    output ram_wr_t      ram_wr,
    output ram_rd_addr_t ram_rd_addr,
    input  ram_rd_data_t ram_rd_data,
    output result_t      result
);

    phase_t             phase_reg, phase_next;
    logic [7:0]         class_reg, class_next;
    logic [7:0]         id_reg, id_next;
    logic [15:0]        exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]   rcv_len_reg, rcv_len_next;
    logic [7:0]         sum_a_reg, sum_a_next;
    logic [7:0]         sum_b_reg, sum_b_next;
    logic signed [30:0] lat_reg, lat_next;
    logic signed [31:0] lon_reg, lon_next;
    logic [7:0]         sats_reg, sats_next;
    logic [1:0]         fix_reg, fix_next;
    logic [15:0]        count_reg, count_next;
    logic               frame_ok;

    logic [7:0]       acc_a;
    logic [7:0]       acc_b;
    logic [15:0]      full_len;
    logic             room;
    logic [LEN_W-1:0] rcv_len_inc;
    logic [7:0]       fix_code;

    // Running Fletcher sums with the current byte folded in.
    assign acc_a       = sum_a_reg + rx_byte;
    assign acc_b       = sum_b_reg + acc_a;
    assign full_len    = {rx_byte, exp_len_reg[7:0]};
    assign room        = rcv_len_reg < LEN_W'(MAX_PAYLOAD);
    assign rcv_len_inc = room ? rcv_len_reg + 1'b1 : rcv_len_reg;
    assign fix_code    = word_byte(ram_rd_data.b_data, LANE_FIX);

    // The decode words are read every cycle. The last payload write is at least
    // two accepted beats ahead of the CKB beat, so the registered read data
    // always holds the finished payload when the frame completes.
    assign ram_rd_addr.a_addr = (id_reg == ID_POSLLH) ? WORD_LON : WORD_SATS;
    assign ram_rd_addr.b_addr = WORD_LAT;

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SYNC1: begin
                if (rx_byte == SYNC_FIRST) phase_next = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (rx_byte == SYNC_SECOND) phase_next = PH_CLASS;
                else if (rx_byte != SYNC_FIRST) phase_next = PH_SYNC1;
            end
            PH_CLASS:  phase_next = PH_ID;
            PH_ID:     phase_next = PH_LEN_LO;
            PH_LEN_LO: phase_next = PH_LEN_HI;
            PH_LEN_HI: begin
                if (full_len > 16'(MAX_PAYLOAD)) phase_next = PH_SYNC1;
                else if (full_len == 16'h0) phase_next = PH_CKA;
                else phase_next = PH_DATA;
            end
            PH_DATA: begin
                if (16'(rcv_len_inc) >= exp_len_reg) phase_next = PH_CKA;
            end
            PH_CKA: phase_next = (rx_byte == sum_a_reg) ? PH_CKB : PH_SYNC1;
            PH_CKB: phase_next = PH_SYNC1;
            default: phase_next = PH_SYNC1;
        endcase
    end

    always_comb begin
        class_next   = class_reg;
        id_next      = id_reg;
        exp_len_next = exp_len_reg;
        rcv_len_next = rcv_len_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        lat_next     = lat_reg;
        lon_next     = lon_reg;
        sats_next    = sats_reg;
        fix_next     = fix_reg;
        count_next   = count_reg;
        frame_ok     = 1'b0;
        ram_wr.en    = 1'b0;
        ram_wr.addr  = rcv_len_reg[BA_W-1:2];
        ram_wr.lane  = rcv_len_reg[1:0];
        ram_wr.data  = rx_byte;
        case (phase_reg)
            PH_CLASS: begin
                class_next = rx_byte;
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
            end
            PH_ID: begin
                id_next    = rx_byte;
                sum_a_next = acc_a;
                sum_b_next = acc_b;
            end
            PH_LEN_LO: begin
                exp_len_next = {8'h00, rx_byte};
                sum_a_next   = acc_a;
                sum_b_next   = acc_b;
            end
            PH_LEN_HI: begin
                exp_len_next = full_len;
                rcv_len_next = '0;
                sum_a_next   = acc_a;
                sum_b_next   = acc_b;
            end
            PH_DATA: begin
                sum_a_next   = acc_a;
                sum_b_next   = acc_b;
                ram_wr.en    = in_fire && room;
                rcv_len_next = rcv_len_inc;
            end
            PH_CKB: begin
                if (rx_byte == sum_b_reg) begin
                    frame_ok   = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (class_reg == CLASS_NAV && id_reg == ID_POSLLH) begin
                        lon_next = ram_rd_data.a_data;
                        lat_next = ram_rd_data.b_data[30:0];
                    end else if (class_reg == CLASS_NAV && id_reg == ID_SOL) begin
                        sats_next = word_byte(ram_rd_data.a_data, LANE_SATS);
                        if (fix_code == FIX_CODE_2D) fix_next = FIX_2D;
                        else if (fix_code == FIX_CODE_3D) fix_next = FIX_3D;
                        else fix_next = FIX_NONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SYNC1;
            class_reg   <= '0;
            id_reg      <= '0;
            exp_len_reg <= '0;
            rcv_len_reg <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            lat_reg     <= '0;
            lon_reg     <= '0;
            sats_reg    <= '0;
            fix_reg     <= FIX_NONE;
            count_reg   <= '0;
        end else if (in_fire) begin
            phase_reg   <= phase_next;
            class_reg   <= class_next;
            id_reg      <= id_next;
            exp_len_reg <= exp_len_next;
            rcv_len_reg <= rcv_len_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            lat_reg     <= lat_next;
            lon_reg     <= lon_next;
            sats_reg    <= sats_next;
            fix_reg     <= fix_next;
            count_reg   <= count_next;
        end
    end

    assign result.frame_ok    = frame_ok;
    assign result.latitude    = lat_next;
    assign result.longitude   = lon_next;
    assign result.satellites  = sats_next;
    assign result.fix_state   = fix_next;
    assign result.frame_count = count_next;

endmodule

/* design/gfp_out_skid.sv */
module gfp_out_skid
    import gfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [1:0] count_reg, count_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != 2'd0;
    assign ready     = count_reg != 2'd2;
    assign out_data  = head_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        else if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (count_reg == 2'd2) begin
                head_reg <= tail_reg;
                if (push) tail_reg <= push_data;
            end else if (push) begin
                head_reg <= push_data;
            end
        end else if (push) begin
            if (count_reg == 2'd0) head_reg <= push_data;
            else tail_reg <= push_data;
        end
    end

endmodule

/* design/gnss_binary_frame_parser.sv */
// Channel  | Direction | Ports                      | Beat contents
// ---------+-----------+----------------------------+-----------------------------------
// s_       | in        | s_tvalid s_tready s_tdata  | one received serial byte
// m_       | out       | m_tvalid m_tready m_tdata  | decoded position, fix and counters
//          |           | m_tuser                    | frame-complete flag
//
// Every input beat produces exactly one output beat, one byte per clock when
// neither side stalls; the result is offered in the cycle after the input is
// taken. The rate is set by the byte-at-a-time parse loop, whose checksum add
// and payload buffer write both complete in the cycle the byte is accepted.
// A two-entry output buffer lets input continue while one result waits.
// aresetn is synchronous and active low; the payload buffer reads as zero after
// reset through per-word valid bits, so no clearing pass is needed.
module gnss_binary_frame_parser
    import gfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [30:0] latitude, [62:31] longitude, [70:63] satellites, [72:71] fix_state,
    // [88:73] frame_count, [95:89] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser    // [0] frame_ok
);

    logic         in_fire;
    ram_wr_t      ram_wr;
    ram_rd_addr_t ram_rd_addr;
    ram_rd_data_t ram_rd_data;
    result_t      result;
    result_t      out_res;

    // A beat is taken whenever the output buffer has a free slot.
    assign in_fire = s_tvalid && s_tready;

    gfp_payload_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sync hunt, header capture, checksum and frame decode.
    gfp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .rx_byte     (s_tdata),
        .ram_wr      (ram_wr),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .result      (result)
    );

    gfp_out_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result fields from the lowest bit up, zero-filled to whole bytes.
    assign m_tdata = {7'h00, out_res.frame_count, out_res.fix_state, out_res.satellites,
                      out_res.longitude, out_res.latitude};
    assign m_tuser = out_res.frame_ok;

endmodule

/* design/gfp_checker.sv */
module gfp_checker
    import gfp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    logic [15:0] last_count_reg;
    logic [2:0]  inflight_reg;
    logic        in_beat;
    logic        out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg <= '0;
            inflight_reg   <= '0;
        end else begin
            if (out_beat) last_count_reg <= m_tdata[88:73];
            inflight_reg <= inflight_reg + 3'(in_beat) - 3'(out_beat);
        end
    end

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // The frame counter moves by one exactly on beats that complete a good frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_beat |-> (m_tuser ? (m_tdata[88:73] == last_count_reg + 16'd1)
                              : (m_tdata[88:73] == last_count_reg)))
        else $error("frame count out of step with frame flag");

    // One result per input byte: never more results than bytes, never more than two held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg <= 3'd2) && (!out_beat || inflight_reg != 3'd0))
        else $error("result count does not match accepted bytes");

    // The fix field never carries the unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[72:71] != 2'd3)
        else $error("invalid fix code on output");

    // Nothing is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind gnss_binary_frame_parser gfp_checker u_gfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/tb_gnss_binary_frame_parser.sv */
module tb_gnss_binary_frame_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import gfp_pkg::*;

    // One entry of the byte stream waiting to go out. A marker entry carries no
    // byte: it makes the sender wait until every result owed so far has come back.
    typedef struct packed {
        logic       drain;
        logic [7:0] value;
    } stim_t;

    typedef enum int {
        CK_GOOD,
        CK_BAD_A,
        CK_BAD_B
    } ck_damage_t;

    localparam int RANDOM_BYTES = 340;
    localparam int IDLE_PCT     = 37;
    localparam int HOLD_AT      = 420;   // beats sent when the long output stall begins
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LO     = 500;   // window of beats with no idling on either side
    localparam int QUIET_HI     = 650;
    localparam int STALL_LIMIT  = 1000;  // cycles without any beat before giving up
    localparam int TAIL_CYCLES  = 8;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    gnss_binary_frame_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Byte stream still to be sent and the reports owed by the parser, oldest first.
    stim_t      stim_q[$];
    result_t    pending_reports[$];
    logic [7:0] body[$];

    int beats_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int hold_left    = 0;
    int hold_done    = 0;
    int stall_cycles = 0;
    int drains_done  = 0;
    logic quiet;

    assign quiet = (beats_sent >= QUIET_LO) && (beats_sent < QUIET_HI);

    // Shadow copy of the parser state, advanced once per accepted input beat.
    phase_t      rx_phase;
    logic [7:0]  frm_class;
    logic [7:0]  frm_id;
    logic [15:0] frm_len;
    int          frm_got;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    logic [7:0]  pay_mem [MAX_PAYLOAD];
    logic [31:0] lat_q;
    logic [31:0] lon_q;
    logic [7:0]  sats_q;
    logic [1:0]  fix_q;
    logic [15:0] good_cnt;

    // Run statistics for the closing summary.
    int posllh_frames = 0;
    int sol_frames    = 0;
    int long_drops    = 0;
    int sum_failures  = 0;

    function automatic void clear_tracker();
        rx_phase  = PH_SYNC1;
        frm_class = '0;
        frm_id    = '0;
        frm_len   = '0;
        frm_got   = 0;
        ck_a      = '0;
        ck_b      = '0;
        foreach (pay_mem[i]) pay_mem[i] = 8'h00;
        lat_q     = '0;
        lon_q     = '0;
        sats_q    = '0;
        fix_q     = FIX_NONE;
        good_cnt  = '0;
    endfunction

    function automatic void fold_sum(input logic [7:0] b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
    endfunction

    // Offsets past the buffer read as zero.
    function automatic logic [7:0] pay_byte(input int pos);
        return (pos < MAX_PAYLOAD) ? pay_mem[pos] : 8'h00;
    endfunction

    function automatic logic [31:0] pay_word(input int pos);
        return {pay_byte(pos + 3), pay_byte(pos + 2), pay_byte(pos + 1), pay_byte(pos)};
    endfunction

    // Works out the report that one received byte produces.
    function automatic result_t parse_rx_byte(input logic [7:0] b);
        result_t    r;
        logic [7:0] code;
        r.frame_ok = 1'b0;
        case (rx_phase)
            PH_SYNC1: begin
                if (b == SYNC_FIRST) rx_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                // A repeated first sync byte keeps us waiting for the second one.
                if (b == SYNC_SECOND) rx_phase = PH_CLASS;
                else if (b != SYNC_FIRST) rx_phase = PH_SYNC1;
            end
            PH_CLASS: begin
                frm_class = b;
                ck_a      = b;
                ck_b      = b;
                rx_phase  = PH_ID;
            end
            PH_ID: begin
                frm_id = b;
                fold_sum(b);
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                frm_len = {8'h00, b};
                fold_sum(b);
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                frm_len[15:8] = b;
                frm_got       = 0;
                fold_sum(b);
                if (int'(frm_len) > MAX_PAYLOAD) begin
                    rx_phase = PH_SYNC1;
                    long_drops++;
                end else if (frm_len == 16'd0) begin
                    rx_phase = PH_CKA;
                end else begin
                    rx_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                fold_sum(b);
                if (frm_got < MAX_PAYLOAD) begin
                    pay_mem[frm_got] = b;
                    frm_got++;
                end
                if (frm_got >= int'(frm_len)) rx_phase = PH_CKA;
            end
            PH_CKA: begin
                if (b != ck_a) sum_failures++;
                rx_phase = (b == ck_a) ? PH_CKB : PH_SYNC1;
            end
            PH_CKB: begin
                if (b == ck_b) begin
                    r.frame_ok = 1'b1;
                    good_cnt   = good_cnt + 16'd1;
                    // Decoding reads fixed offsets, so a short frame picks up
                    // whatever earlier frames left in the buffer.
                    if (frm_class == CLASS_NAV && frm_id == ID_POSLLH) begin
                        lon_q = pay_word(OFS_LON);
                        lat_q = pay_word(OFS_LAT);
                        posllh_frames++;
                    end else if (frm_class == CLASS_NAV && frm_id == ID_SOL) begin
                        code   = pay_byte(OFS_FIX);
                        sats_q = pay_byte(OFS_SATS);
                        if (code == FIX_CODE_2D) fix_q = FIX_2D;
                        else if (code == FIX_CODE_3D) fix_q = FIX_3D;
                        else fix_q = FIX_NONE;
                        sol_frames++;
                    end
                end else begin
                    sum_failures++;
                end
                rx_phase = PH_SYNC1;
            end
            default: begin
                rx_phase = PH_SYNC1;
            end
        endcase
        r.latitude    = lat_q[30:0];
        r.longitude   = lon_q;
        r.satellites  = sats_q;
        r.fix_state   = fix_q;
        r.frame_count = good_cnt;
        return r;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        stim_q.push_back({1'b0, b});
    endfunction

    function automatic void push_drain();
        stim_q.push_back({1'b1, 8'h00});
    endfunction

    function automatic void fill_body(input int n);
        body.delete();
        repeat (n) body.push_back(8'($urandom));
    endfunction

    // Frames the current body. The length field is given apart from the body so
    // that overlong headers can be sent without their payload.
    function automatic void queue_frame(input logic [7:0] cls, input logic [7:0] id,
                                        input logic [15:0] len_field,
                                        input ck_damage_t damage);
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] hdr [4];
        ca = 8'h00;
        cb = 8'h00;
        hdr = '{cls, id, len_field[7:0], len_field[15:8]};
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        foreach (hdr[i]) begin
            push_byte(hdr[i]);
            ca = ca + hdr[i];
            cb = cb + ca;
        end
        foreach (body[i]) begin
            push_byte(body[i]);
            ca = ca + body[i];
            cb = cb + ca;
        end
        if (damage == CK_BAD_A) ca = ca ^ 8'($urandom_range(1, 255));
        if (damage == CK_BAD_B) cb = cb ^ 8'($urandom_range(1, 255));
        push_byte(ca);
        push_byte(cb);
        body.delete();
    endfunction

    function automatic void set_word(input int pos, input logic [31:0] w);
        for (int i = 0; i < 4; i++) body[pos + i] = w[8*i +: 8];
    endfunction

    function automatic void flag_field(input string name, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Sender. A beat stays on the bus until taken; between beats the sender idles
    // at random, except in the quiet window and while the output is held off, so
    // that the parser's small output buffer fills and back-pressures the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) beats_sent <= beats_sent + 1;
            if (!s_tvalid || s_tready) begin
                if (stim_q.size() > 0 && stim_q[0].drain) begin
                    // Pause: release only once the last beat has gone and its
                    // report has come back.
                    s_tvalid <= 1'b0;
                    if (!s_tvalid && results_seen == beats_sent) begin
                        void'(stim_q.pop_front());
                        drains_done <= drains_done + 1;
                    end
                end else if (stim_q.size() > 0 &&
                             (quiet || hold_left > 0 || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stim_q[0].value;
                    void'(stim_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Random back-pressure, plus one long hold-off counted here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_done == 0 && beats_sent >= HOLD_AT) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Checker. Each output beat is matched against the oldest owed report, then
    // any input beat taken on the same edge adds its own report to the store.
    always @(posedge aclk) begin : check_reports
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected output beat, expected none, got data %0h flag %0b",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    flag_field("frame_ok", want.frame_ok, m_tuser);
                    flag_field("latitude", $unsigned(want.latitude), m_tdata[30:0]);
                    flag_field("longitude", $unsigned(want.longitude), m_tdata[62:31]);
                    flag_field("satellites", want.satellites, m_tdata[70:63]);
                    flag_field("fix_state", want.fix_state, m_tdata[72:71]);
                    flag_field("frame_count", want.frame_count, m_tdata[88:73]);
                    flag_field("pad", '0, m_tdata[95:89]);
                end
            end
            if (s_tvalid && s_tready) pending_reports.push_back(parse_rx_byte(s_tdata));
        end
    end

    // Watchdog on the handshakes: too long without any beat means a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("gnss_binary_frame_parser regression: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int         random_end;
        int         pick;
        int         sz;
        int         mid_mark;
        logic [7:0] cls;
        logic [7:0] id;
        logic [15:0] len_field;
        ck_damage_t damage;

        clear_tracker();

        // Line noise at both byte extremes and a stray second sync byte, then a
        // run of first sync bytes that must keep the hunt waiting for 0x62.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_SECOND);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        // Position report with the extreme longitude and latitude words.
        fill_body(28);
        set_word(OFS_LON, 32'h8000_0000);
        set_word(OFS_LAT, 32'h7FFF_FFFF);
        queue_frame(CLASS_NAV, ID_POSLLH, 16'd28, CK_GOOD);
        // A foreign byte after the first sync byte restarts the hunt.
        push_byte(SYNC_FIRST);
        push_byte(8'h00);
        // Full solution frame: 3D fix and the largest satellite count.
        fill_body(52);
        body[OFS_FIX]  = FIX_CODE_3D;
        body[OFS_SATS] = 8'hFF;
        queue_frame(CLASS_NAV, ID_SOL, 16'd52, CK_GOOD);
        // Short solution frame: 2D fix, satellite count left from the last frame.
        fill_body(12);
        body[OFS_FIX] = FIX_CODE_2D;
        queue_frame(CLASS_NAV, ID_SOL, 16'd12, CK_GOOD);
        // Unknown fix code maps to no fix.
        fill_body(11);
        body[OFS_FIX] = 8'h07;
        queue_frame(CLASS_NAV, ID_SOL, 16'd11, CK_GOOD);
        // Empty frame of an unknown class goes straight to the checksum.
        queue_frame(8'hFF, 8'hFF, 16'd0, CK_GOOD);
        // Overlong lengths: one past the buffer, one set only by the high byte, and all ones.
        queue_frame(CLASS_NAV, ID_POSLLH, 16'(MAX_PAYLOAD + 1), CK_GOOD);
        queue_frame(CLASS_NAV, ID_POSLLH, 16'h0100, CK_GOOD);
        queue_frame(CLASS_NAV, ID_SOL, 16'hFFFF, CK_GOOD);
        // Checksum failures on either byte.
        fill_body(20);
        queue_frame(CLASS_NAV, ID_POSLLH, 16'd20, CK_BAD_A);
        fill_body(20);
        queue_frame(CLASS_NAV, ID_POSLLH, 16'd20, CK_BAD_B);
        // Largest payload the buffer takes.
        fill_body(MAX_PAYLOAD);
        set_word(OFS_LON, 32'h7FFF_FFFF);
        set_word(OFS_LAT, 32'hFFFF_FFFF);
        queue_frame(CLASS_NAV, ID_POSLLH, 16'(MAX_PAYLOAD), CK_GOOD);
        // A NAV id under another class, another id under NAV: counted only.
        fill_body(30);
        queue_frame(8'h02, ID_POSLLH, 16'd30, CK_GOOD);
        fill_body(52);
        queue_frame(CLASS_NAV, 8'h07, 16'd52, CK_GOOD);
        // Empty position report decodes whatever is left in the buffer.
        queue_frame(CLASS_NAV, ID_POSLLH, 16'd0, CK_GOOD);

        // Random part, mostly well-formed frames with random content, with a
        // pause for a full drain at its start and again halfway through.
        push_drain();
        random_end = stim_q.size() + RANDOM_BYTES;
        mid_mark   = stim_q.size() + RANDOM_BYTES / 2;
        while (stim_q.size() < random_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 3) == 0) push_byte(SYNC_FIRST);
                    else push_byte(8'($urandom));
                end
            end else begin
                cls = ($urandom_range(0, 3) != 0) ? CLASS_NAV : 8'($urandom);
                case ($urandom_range(0, 4))
                    0, 1:    id = ID_POSLLH;
                    2, 3:    id = ID_SOL;
                    default: id = 8'($urandom);
                endcase
                pick = $urandom_range(0, 9);
                if (pick < 5) sz = $urandom_range(0, 16);
                else if (pick < 8) sz = $urandom_range(12, 52);
                else sz = $urandom_range(53, MAX_PAYLOAD);
                fill_body(sz);
                if (id == ID_SOL && sz > OFS_FIX && $urandom_range(0, 2) != 0)
                    body[OFS_FIX] = $urandom_range(0, 1) ? FIX_CODE_2D : FIX_CODE_3D;
                len_field = 16'(sz);
                damage    = CK_GOOD;
                case ($urandom_range(0, 19))
                    0: damage = CK_BAD_A;
                    1: damage = CK_BAD_B;
                    2: len_field = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
                    default: ;
                endcase
                queue_frame(cls, id, len_field, damage);
            end
            if (mid_mark > 0 && stim_q.size() >= mid_mark) begin
                push_drain();
                mid_mark = 0;
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() > 0 || s_tvalid || results_seen != beats_sent)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending_reports.size() != 0) begin
            $display("%0t: %0d reports still owed at the end, expected none",
                     $time, pending_reports.size());
            mismatches++;
        end
        $display("Sent %0d bytes and checked %0d reports over %0d full drains, %0d mismatches.",
                 beats_sent, results_seen, drains_done, mismatches);
        $display("Saw %0d good frames (%0d position, %0d solution),",
                 good_cnt, posllh_frames, sol_frames);
        $display("    %0d checksum fails and %0d overlong headers.",
                 sum_failures, long_drops);
        if (mismatches == 0) begin
            $display("gnss_binary_frame_parser regression: pass");
        end else begin
            $display("gnss_binary_frame_parser regression: fail");
        end
        $finish;
    end

endmodule
